>>> rtl/pffl_pkg.sv
// Shared types and constants for the page frame free list.
package pffl_pkg;

    localparam int FRAME_NUM_BITS_DEF = 16;
    localparam int PAGE_BYTES_DEF     = 4096;

    // Widest frame index a command can carry over the legal parameter range
    localparam int FN_MAX_W = 25;

    localparam logic [31:0] KIND_USABLE = 32'd1;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_REGION = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CFG_KERNEL_END = 2'd0,
        CFG_MODULE_END = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ALLOC,
        OP_RANGE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK
    } back_state_t;

    // One classified request: push frames first..stop-1, pop one, or report only
    typedef struct packed {
        op_t                 op;
        logic [FN_MAX_W-1:0] first;
        logic [FN_MAX_W-1:0] stop;
    } cmd_t;

    // Frames addressable within 32 bits, capped by the link store depth
    function automatic logic [33:0] frame_limit(input int fnb, input int ps);
        logic [33:0] lim;
        begin
            if (fnb < 32 - ps)
                lim = 34'd1 << fnb;
            else
                lim = 34'd1 << (32 - ps);
            return lim;
        end
    endfunction

endpackage

>>> rtl/pffl_front.sv
// Request capture, configuration registers and request classification.
module pffl_front #(
    parameter int FRAME_NUM_BITS = pffl_pkg::FRAME_NUM_BITS_DEF,
    parameter int PAGE_BYTES     = pffl_pkg::PAGE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        req_type,
    input  logic [31:0]       frame_addr,
    input  logic [31:0]       region_base,
    input  logic [32:0]       region_length,
    input  logic [31:0]       region_kind,
    input  logic              cfg_wr,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output pffl_pkg::cmd_t    q_cmd,
    output logic              pending
);

    localparam int          PS  = $clog2(PAGE_BYTES);
    localparam logic [33:0] LIM = pffl_pkg::frame_limit(FRAME_NUM_BITS, PS);
    localparam logic [33:0] PAGE_MASK = 34'(PAGE_BYTES - 1);

    logic        pend_reg;
    logic [1:0]  type_reg;
    logic [31:0] addr_reg;
    logic [31:0] base_reg;
    logic [32:0] len_reg;
    logic [31:0] kind_reg;
    logic [31:0] kernel_end_reg;
    logic [31:0] module_end_reg;

    logic [31:0] start_a;
    logic [31:0] start_b;
    logic [33:0] first_w;
    logic [33:0] end_w;
    logic [33:0] stop_w;
    logic [33:0] fn_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            kernel_end_reg <= '0;
            module_end_reg <= '0;
        end
        else
        begin
            if (accept)
                pend_reg <= 1'b1;
            else if (q_push)
                pend_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (cfg_index == pffl_pkg::CFG_KERNEL_END)
                    kernel_end_reg <= cfg_data;
                else if (cfg_index == pffl_pkg::CFG_MODULE_END)
                    module_end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req_type;
            addr_reg <= frame_addr;
            base_reg <= region_base;
            len_reg  <= region_length;
            kind_reg <= region_kind;
        end
    end

    always_comb
    begin
        start_a = (base_reg < kernel_end_reg) ? kernel_end_reg : base_reg;
        start_b = (start_a < module_end_reg) ? module_end_reg : start_a;
        first_w = (34'(start_b) + PAGE_MASK) >> PS;
        end_w   = 34'(base_reg) + 34'(len_reg);
        stop_w  = ((end_w >> PS) > LIM) ? LIM : (end_w >> PS);
        fn_w    = 34'(addr_reg) >> PS;

        q_cmd.op    = pffl_pkg::OP_NOP;
        q_cmd.first = '0;
        q_cmd.stop  = '0;
        unique case (type_reg)
            pffl_pkg::REQ_ALLOC:
                q_cmd.op = pffl_pkg::OP_ALLOC;
            pffl_pkg::REQ_FREE:
            begin
                if (fn_w < LIM)
                begin
                    q_cmd.op    = pffl_pkg::OP_RANGE;
                    q_cmd.first = fn_w[pffl_pkg::FN_MAX_W-1:0];
                    q_cmd.stop  = fn_w[pffl_pkg::FN_MAX_W-1:0] + 1'b1;
                end
            end
            pffl_pkg::REQ_REGION:
            begin
                if (kind_reg == pffl_pkg::KIND_USABLE)
                begin
                    q_cmd.op    = pffl_pkg::OP_RANGE;
                    q_cmd.first = first_w[pffl_pkg::FN_MAX_W-1:0];
                    q_cmd.stop  = stop_w[pffl_pkg::FN_MAX_W-1:0];
                end
            end
            default:
                q_cmd.op = pffl_pkg::OP_NOP;
        endcase
    end

    assign q_push  = pend_reg && !q_full;
    assign pending = pend_reg;

endmodule

>>> rtl/pffl_queue.sv
// Two-entry command queue between classifier and executor.
module pffl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pffl_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output pffl_pkg::cmd_t head_cmd
);

    pffl_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/pffl_back.sv
// Executor: link store, list head, free counter and result registers.
module pffl_back #(
    parameter int FRAME_NUM_BITS = pffl_pkg::FRAME_NUM_BITS_DEF,
    parameter int PAGE_BYTES     = pffl_pkg::PAGE_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  pffl_pkg::cmd_t        q_cmd,
    output logic                  q_pop,
    output logic                  active,
    output logic                  done,
    output logic [31:0]           alloc_addr,
    output logic [FRAME_NUM_BITS:0] free_count
);

    localparam int FNB   = FRAME_NUM_BITS;
    localparam int PS    = $clog2(PAGE_BYTES);
    localparam int CW    = (33 - PS > FNB + 1) ? (33 - PS) : (FNB + 1);
    localparam int DEPTH = 1 << FNB;

    pffl_pkg::back_state_t state_reg, state_next;
    logic [FNB-1:0] head_reg, head_next;
    logic [FNB:0]   count_reg, count_next;
    logic [CW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  stop_reg, stop_next;
    logic           done_reg, done_next;
    logic [31:0]    addr_reg, addr_next;
    logic [FNB-1:0] rd_reg;
    logic           rd_en;
    logic           wr_en;
    logic [63:0]    head_bytes;

    logic [FNB-1:0] link_mem [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pffl_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        stop_reg <= stop_next;
        addr_reg <= addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= link_mem[head_reg];
        if (wr_en)
            link_mem[cur_reg[FNB-1:0]] <= head_reg;
    end

    assign head_bytes = 64'(head_reg) << PS;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        stop_next  = stop_reg;
        done_next  = 1'b0;
        addr_next  = addr_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;

        unique case (state_reg)
            pffl_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        pffl_pkg::OP_ALLOC:
                        begin
                            if (head_reg == '0)
                            begin
                                done_next = 1'b1;
                                addr_next = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = pffl_pkg::ST_ALLOC;
                            end
                        end
                        pffl_pkg::OP_RANGE:
                        begin
                            cur_next   = q_cmd.first[CW-1:0];
                            stop_next  = q_cmd.stop[CW-1:0];
                            state_next = pffl_pkg::ST_WALK;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            addr_next = '0;
                        end
                    endcase
                end
            end
            pffl_pkg::ST_ALLOC:
            begin
                head_next = rd_reg;
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
                addr_next  = head_bytes[31:0];
                done_next  = 1'b1;
                state_next = pffl_pkg::ST_IDLE;
            end
            pffl_pkg::ST_WALK:
            begin
                if (cur_reg < stop_reg)
                begin
                    // frame zero is the end marker; a full counter drops the push
                    if (cur_reg != '0 && !count_reg[FNB])
                    begin
                        wr_en      = 1'b1;
                        head_next  = cur_reg[FNB-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    cur_next = cur_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    addr_next  = '0;
                    state_next = pffl_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pffl_pkg::ST_IDLE;
        endcase
    end

    assign active     = (state_reg != pffl_pkg::ST_IDLE);
    assign done       = done_reg;
    assign alloc_addr = addr_reg;
    assign free_count = count_reg;

endmodule

>>> rtl/page_frame_free_list.sv
// Top level of the page frame free list allocator.
//
//   channel   direction  handshake              payload
//   request   in         start && !busy         req_type, frame_addr, region_*
//   result    out        done (one cycle)       alloc_addr, free_count
//   config    in         cfg_valid && cfg_ready cfg_index, cfg_data
//
// One request at a time. Unknown requests, unusable regions, frees beyond memory
// and allocs on an empty list finish from idle; other allocs add a registered
// link read; region adds and frees walk their candidate frames, one per cycle.
// busy drops with done, so the next word can enter on the result edge.
// Reset clears head, count and config; the link store is not cleared.
// done cannot be held off; cfg_ready is always high.
module page_frame_free_list #(
    parameter int FRAME_NUM_BITS = pffl_pkg::FRAME_NUM_BITS_DEF,
    parameter int PAGE_BYTES     = pffl_pkg::PAGE_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              req_type,
    input  logic [31:0]             frame_addr,
    input  logic [31:0]             region_base,
    input  logic [32:0]             region_length,
    input  logic [31:0]             region_kind,
    output logic                    done,
    output logic [31:0]             alloc_addr,
    output logic [FRAME_NUM_BITS:0] free_count,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    logic           accept;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_valid;
    logic           pending;
    logic           active;
    pffl_pkg::cmd_t front_cmd;
    pffl_pkg::cmd_t back_cmd;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign busy      = pending || q_valid || active;

    pffl_front #(
        .FRAME_NUM_BITS (FRAME_NUM_BITS),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (req_type),
        .frame_addr    (frame_addr),
        .region_base   (region_base),
        .region_length (region_length),
        .region_kind   (region_kind),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (front_cmd),
        .pending       (pending)
    );

    pffl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_cmd (back_cmd)
    );

    pffl_back #(
        .FRAME_NUM_BITS (FRAME_NUM_BITS),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (back_cmd),
        .q_pop      (q_pop),
        .active     (active),
        .done       (done),
        .alloc_addr (alloc_addr),
        .free_count (free_count)
    );

endmodule

>>> rtl/pffl_checker.sv
// Port-level checks for the page frame free list, bound to the top level.
module pffl_checker #(
    parameter int FRAME_NUM_BITS = pffl_pkg::FRAME_NUM_BITS_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic [FRAME_NUM_BITS:0] free_count
);

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // one request in flight, so results never come back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("results in consecutive cycles");

    // the count only moves while work is in progress or with its result
    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(free_count) |-> busy || done)
        else $error("free count changed while idle");

endmodule

bind page_frame_free_list pffl_checker #(
    .FRAME_NUM_BITS (FRAME_NUM_BITS)
) u_pffl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .free_count (free_count)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the page frame free list: directed table, then random phases.
module testbench;

    localparam int FNB = 16;
    localparam int PAGE = 4096;
    localparam int SLOTS = 1 << FNB;
    localparam longint unsigned ADDR_FRAMES = (64'd1 << 32) / PAGE;
    localparam int FRAME_CAP = (ADDR_FRAMES < SLOTS) ? int'(ADDR_FRAMES) : SLOTS;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int PHASES = 5;
    localparam int WORDS_PER_PHASE = 150;
    localparam int STALL_LIMIT = 400000;
    localparam int PLAN_ROWS = 24;

    typedef struct packed {
        logic [31:0]  addr;
        logic [FNB:0] count;
    } reply_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] faddr;
        logic [31:0] base;
        logic [32:0] len;
        logic [31:0] kind;
    } req_word_t;

    typedef struct packed {
        req_word_t w;
        logic      typed;
        reply_t    want;
    } plan_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [1:0]   req_type = '0;
    logic [31:0]  frame_addr = '0;
    logic [31:0]  region_base = '0;
    logic [32:0]  region_length = '0;
    logic [31:0]  region_kind = '0;
    logic         done;
    logic [31:0]  alloc_addr;
    logic [FNB:0] free_count;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = pffl_pkg::CFG_KERNEL_END;
    logic [31:0]  cfg_data = '0;

    // Free list mirror
    logic [FNB-1:0] fl_link [0:SLOTS-1];
    logic [FNB-1:0] fl_head = '0;
    logic [FNB:0]   fl_count = '0;
    logic [31:0]    fl_kernel_end = '0;
    logic [31:0]    fl_module_end = '0;

    reply_t      reply_q [$];
    logic [31:0] taken_q [$];
    bit          steady = 1'b0;
    int          errors = 0;
    int          checked = 0;
    int          quiet_cycles = 0;
    int          n_alloc = 0;
    int          n_free = 0;
    int          n_region = 0;
    int          n_other = 0;

    page_frame_free_list #(
        .FRAME_NUM_BITS(FNB),
        .PAGE_BYTES    (PAGE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .frame_addr   (frame_addr),
        .region_base  (region_base),
        .region_length(region_length),
        .region_kind  (region_kind),
        .done         (done),
        .alloc_addr   (alloc_addr),
        .free_count   (free_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void fl_push(input longint unsigned fn);
        if (fn == 0 || fn >= FRAME_CAP)
            return;
        if (fl_count >= SLOTS)
            return;
        fl_link[fn] = fl_head;
        fl_head = fn[FNB-1:0];
        fl_count = fl_count + 1'b1;
    endfunction

    function automatic logic [FNB-1:0] fl_pop();
        logic [FNB-1:0] fn;
        fn = fl_head;
        if (fn != 0)
        begin
            fl_head = fl_link[fn];
            // count sticks at zero once a double free has corrupted the list
            if (fl_count != 0)
                fl_count = fl_count - 1'b1;
        end
        return fn;
    endfunction

    function automatic void fl_add_region(input logic [31:0] base, input logic [32:0] len);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned first;
        longint unsigned stop;
        lo = base;
        hi = lo + len;
        if (lo < fl_kernel_end)
            lo = fl_kernel_end;
        if (lo < fl_module_end)
            lo = fl_module_end;
        first = (lo + PAGE - 1) / PAGE;
        stop = hi / PAGE;
        if (stop > FRAME_CAP)
            stop = FRAME_CAP;
        for (longint unsigned fn = first; fn < stop; fn++)
            fl_push(fn);
    endfunction

    function automatic reply_t fl_apply(input req_word_t w);
        reply_t         r;
        logic [FNB-1:0] fn;
        r.addr = '0;
        case (w.req)
            pffl_pkg::REQ_ALLOC:
            begin
                fn = fl_pop();
                r.addr = 32'(fn) * PAGE;
            end
            pffl_pkg::REQ_FREE:   fl_push(64'(w.faddr / PAGE));
            pffl_pkg::REQ_REGION:
            begin
                if (w.kind == pffl_pkg::KIND_USABLE)
                    fl_add_region(w.base, w.len);
            end
            default:    ;
        endcase
        r.count = fl_count;
        return r;
    endfunction

    function automatic plan_row_t row(input logic [1:0] req, input logic [31:0] faddr,
                                      input logic [31:0] base, input logic [32:0] len,
                                      input logic [31:0] kind, input logic typed,
                                      input logic [31:0] addr, input logic [FNB:0] count);
        plan_row_t p;
        p.w = '{req: req, faddr: faddr, base: base, len: len, kind: kind};
        p.typed = typed;
        p.want = '{addr: addr, count: count};
        return p;
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int        pick;
        int        k;
        int        n;
        int        sf;
        // unused fields carry noise
        w.req = pffl_pkg::REQ_ALLOC;
        w.faddr = $urandom();
        w.base = $urandom();
        w.len = {1'($urandom_range(0, 1)), 32'($urandom())};
        w.kind = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 36)
            w.req = pffl_pkg::REQ_ALLOC;
        else if (pick < 66)
        begin
            w.req = pffl_pkg::REQ_FREE;
            k = $urandom_range(0, 3);
            if (k < 2 && taken_q.size() != 0)
            begin
                n = $urandom_range(0, taken_q.size() - 1);
                w.faddr = taken_q[n];
                taken_q.delete(n);
            end
            else if (k < 3)
                w.faddr = 32'($urandom_range(1, FRAME_CAP - 1) * PAGE);
            if ($urandom_range(0, 7) == 0)
                w.faddr[11:0] = 12'($urandom());
        end
        else if (pick < 95)
        begin
            w.req = pffl_pkg::REQ_REGION;
            k = $urandom_range(0, 99);
            if (k < 75)
            begin
                // a handful of big regions, the rest a few frames
                sf = $urandom_range(0, FRAME_CAP - 1);
                n = (k < 2) ? $urandom_range(256, 4096) : $urandom_range(0, 24);
                w.base = 32'(sf * PAGE);
                if ($urandom_range(0, 3) == 0)
                    w.base = w.base + 32'($urandom_range(0, PAGE - 1));
                w.len = 33'(n * PAGE);
                if ($urandom_range(0, 3) == 0)
                    w.len = w.len + 33'($urandom_range(0, PAGE - 1));
                if ($urandom_range(0, 9) != 0)
                    w.kind = pffl_pkg::KIND_USABLE;
            end
            else if (k < 88)
                w.kind = pffl_pkg::KIND_USABLE;
        end
        else
            w.req = REQ_UNKNOWN;
        return w;
    endfunction

    task automatic send_word(input req_word_t w, input logic typed, input reply_t want);
        reply_t r;
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= w.req;
        frame_addr <= w.faddr;
        region_base <= w.base;
        region_length <= w.len;
        region_kind <= w.kind;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = fl_apply(w);
        reply_q.push_back(typed ? want : r);
        case (w.req)
            pffl_pkg::REQ_ALLOC:
            begin
                n_alloc++;
                if (r.addr != 0)
                    taken_q.push_back(r.addr);
            end
            pffl_pkg::REQ_FREE:   n_free++;
            pffl_pkg::REQ_REGION: n_region++;
            default:    n_other++;
        endcase
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (reply_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input pffl_pkg::cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pffl_pkg::CFG_KERNEL_END: fl_kernel_end = data;
            pffl_pkg::CFG_MODULE_END: fl_module_end = data;
            default:        ;
        endcase
    endtask

    task automatic set_limits(input logic [31:0] kend, input logic [31:0] mend);
        write_reg(pffl_pkg::CFG_KERNEL_END, kend);
        write_reg(pffl_pkg::CFG_MODULE_END, mend);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                $error("result word with nothing outstanding: alloc_addr %h free_count %0d",
                       alloc_addr, free_count);
                errors++;
            end
            else
            begin
                want = reply_q.pop_front();
                checked++;
                if (alloc_addr !== want.addr)
                begin
                    $error("alloc_addr mismatch: expected %h, got %h", want.addr, alloc_addr);
                    errors++;
                end
                if (free_count !== want.count)
                begin
                    $error("free_count mismatch: expected %0d, got %0d", want.count, free_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan [0:PLAN_ROWS-1];
        logic [31:0] kend;
        logic [31:0] mend;
        reply_t      none;
        none = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_limits(32'd0, 32'd0);

        plan[0]  = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd0);
        plan[1]  = row(REQ_UNKNOWN, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd0);
        plan[2]  = row(pffl_pkg::REQ_FREE, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd0);
        plan[3]  = row(pffl_pkg::REQ_FREE, 32'hFFFF_F000, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd0);
        plan[4]  = row(pffl_pkg::REQ_FREE, 32'h0FFF_F000, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd1);
        // unaligned: lands on frame 1
        plan[5]  = row(pffl_pkg::REQ_FREE, 32'h0000_1FFF, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd2);
        plan[6]  = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0000_1000, 17'd1);
        plan[7]  = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0FFF_F000, 17'd0);
        // double free makes frame 7 point at itself; third pop hits the empty counter
        plan[8]  = row(pffl_pkg::REQ_FREE, 32'h0000_7000, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd1);
        plan[9]  = row(pffl_pkg::REQ_FREE, 32'h0000_7000, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'd2);
        plan[10] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0000_7000, 17'd1);
        plan[11] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0000_7000, 17'd0);
        plan[12] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0000_7000, 17'd0);
        plan[13] = row(pffl_pkg::REQ_REGION, 32'h0, 32'h0000_1000, 33'h1_0000, 32'h0,
                       1'b1, 32'h0, 17'd0);
        plan[14] = row(pffl_pkg::REQ_REGION, 32'h0, 32'h0000_1800, 33'h1000,
                       pffl_pkg::KIND_USABLE, 1'b1, 32'h0, 17'd0);
        plan[15] = row(pffl_pkg::REQ_REGION, 32'h0, 32'h0, 33'h5000,
                       pffl_pkg::KIND_USABLE, 1'b1, 32'h0, 17'd4);
        plan[16] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0000_4000, 17'd3);
        plan[17] = row(pffl_pkg::REQ_REGION, 32'h0, 32'hFFFF_F000, 33'h1_0000_0000,
                       pffl_pkg::KIND_USABLE, 1'b1, 32'h0, 17'd3);
        plan[18] = row(pffl_pkg::REQ_REGION, 32'h0, 32'h0FFF_E000, 33'h1_FFFF_FFFF,
                       pffl_pkg::KIND_USABLE, 1'b1, 32'h0, 17'd5);
        plan[19] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0FFF_F000, 17'd4);
        // whole memory: fills the counter, the rest of the walk is dropped
        plan[20] = row(pffl_pkg::REQ_REGION, 32'h0, 32'h0, 33'h1_0000_0000,
                       pffl_pkg::KIND_USABLE, 1'b1, 32'h0, 17'h1_0000);
        plan[21] = row(pffl_pkg::REQ_FREE, 32'h0000_2000, 32'h0, 33'h0, 32'h0,
                       1'b1, 32'h0, 17'h1_0000);
        plan[22] = row(pffl_pkg::REQ_ALLOC, 32'h0, 32'h0, 33'h0, 32'h0,
                       1'b0, 32'h0, 17'd0);
        plan[23] = row(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF,
                       32'hFFFF_FFFF, 1'b0, 32'h0, 17'd0);

        for (int i = 0; i < PLAN_ROWS; i++)
            send_word(plan[i].w, plan[i].typed, plan[i].want);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin kend = 32'h0040_0000; mend = 32'h0012_3456; end
                1:       begin kend = 32'h0000_0FFF; mend = 32'h0800_0001; end
                2:       begin kend = 32'hFFFF_FFFF; mend = 32'h0;         end
                3:       begin kend = 32'h0;         mend = 32'hFFFF_FFFF; end
                default: begin kend = 32'h0;         mend = 32'h0;         end
            endcase
            set_limits(kend, mend);
            steady = (p == 1);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_word(random_word(), 1'b0, none);
            settle();
        end

        $display("covered %0d allocs, %0d frees, %0d region adds, %0d unknown requests",
                 n_alloc, n_free, n_region, n_other);
        $display("%0d result words checked over %0d limit settings", checked, PHASES + 1);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/pffl_pkg.sv
rtl/pffl_front.sv
rtl/pffl_queue.sv
rtl/pffl_back.sv
rtl/page_frame_free_list.sv
rtl/pffl_checker.sv
verif/testbench.sv
